[sv/fzw_pkg.sv]
`timescale 1ns / 1ps

package fzw_pkg;

    // kernel count is padded up to a multiple of this
    localparam int NI_SIZE = 16;
    localparam int NI_BITS = $clog2(NI_SIZE);

    localparam int DIM_W      = 13;
    localparam int HW_W       = 8;
    localparam int C0_W       = 6;
    localparam int BLK_W      = 12;
    localparam int KERN_W     = 13;
    localparam int LANE_W     = 6;
    localparam int CI_W       = 19;
    localparam int DST_W      = 42;
    localparam int SRC_W      = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(4096);
    localparam logic [DIM_W-1:0] RST_DIM = DIM_W'(1);
    localparam logic [HW_W-1:0]  RST_HW  = HW_W'(1);
    localparam logic [C0_W-1:0]  RST_C0  = C0_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_N   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_C   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_H   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_W   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_CUBE_C0 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT  = CFG_IDX_W'(5);

    typedef enum logic [1:0] {
        LAYOUT_NCHW = 2'd0,
        LAYOUT_HWCN = 2'd1,
        LAYOUT_NHWC = 2'd2
    } layout_t;

    // effective (already clamped) configuration
    typedef struct packed {
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] c;
        logic [HW_W-1:0]  h;
        logic [HW_W-1:0]  w;
        logic [C0_W-1:0]  c0;
        layout_t          layout;
    } cfg_t;

    // one destination element as produced by the counter walk
    typedef struct packed {
        logic [DST_W-1:0]  dst;
        logic [CI_W-1:0]   ci;
        logic [KERN_W-1:0] kernel;
        logic [HW_W-1:0]   row;
        logic [HW_W-1:0]   col;
        logic              pad;
        logic              last;
    } elem_t;

    function automatic logic [DIM_W-1:0] clamp_nc(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = RST_DIM;
        else if (v > DIM_MAX)
            r = DIM_MAX;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [HW_W-1:0] clamp_hw(input logic [HW_W-1:0] v);
        return (v == '0) ? RST_HW : v;
    endfunction

    function automatic logic [C0_W-1:0] clamp_c0(input logic [C0_W-1:0] v);
        return (v == '0) ? C0_W'(1) : v;
    endfunction

    // reserved code falls back to nchw
    function automatic layout_t to_layout(input logic [1:0] v);
        layout_t r;
        case (layout_t'(v))
            LAYOUT_HWCN: r = LAYOUT_HWCN;
            LAYOUT_NHWC: r = LAYOUT_NHWC;
            default:     r = LAYOUT_NCHW;
        endcase
        return r;
    endfunction

endpackage

[sv/fzw_walker.sv]
`timescale 1ns / 1ps

module fzw_walker (
    input  logic           clk,
    input  logic           rst_n,
    input  fzw_pkg::cfg_t  cfg,
    input  logic           accept,
    input  logic           restart,
    output fzw_pkg::elem_t elem
);
    import fzw_pkg::*;

    logic [BLK_W-1:0]  blk_reg, blk_next, blk_cur;
    logic [HW_W-1:0]   row_reg, row_next, row_cur;
    logic [HW_W-1:0]   col_reg, col_next, col_cur;
    logic [KERN_W-1:0] kern_reg, kern_next, kern_cur;
    logic [LANE_W-1:0] lane_reg, lane_next, lane_cur;
    logic [DST_W-1:0]  pos_reg, pos_next, pos_cur;

    logic [BLK_W+C0_W-1:0] blk_prod;
    logic [CI_W-1:0]       ci;
    logic [CI_W-1:0]       blk_top;
    logic [DIM_W:0]        n_round;
    logic [DIM_W:0]        n1n0;
    logic                  pad;
    logic                  end_lane, end_kernel, end_col, end_row, end_block, last;

    always_comb
    begin
        blk_cur  = restart ? '0 : blk_reg;
        row_cur  = restart ? '0 : row_reg;
        col_cur  = restart ? '0 : col_reg;
        kern_cur = restart ? '0 : kern_reg;
        lane_cur = restart ? '0 : lane_reg;
        pos_cur  = restart ? '0 : pos_reg;

        blk_prod = blk_cur * cfg.c0;
        ci       = CI_W'(blk_prod) + CI_W'(lane_cur);
        // block ends when its channel range reaches c, i.e. ceil(c / c0) without a divider
        blk_top  = CI_W'(blk_prod) + CI_W'(cfg.c0);

        n_round  = (DIM_W+1)'(cfg.n) + (DIM_W+1)'(NI_SIZE - 1);
        n1n0     = {n_round[DIM_W:NI_BITS], NI_BITS'(0)};

        pad        = (ci >= CI_W'(cfg.c)) || (kern_cur >= cfg.n);
        end_lane   = ((LANE_W+1)'(lane_cur) + 1'b1) >= (LANE_W+1)'(cfg.c0);
        end_kernel = ((KERN_W+1)'(kern_cur) + 1'b1) >= n1n0;
        end_col    = ((HW_W+1)'(col_cur) + 1'b1) >= (HW_W+1)'(cfg.w);
        end_row    = ((HW_W+1)'(row_cur) + 1'b1) >= (HW_W+1)'(cfg.h);
        end_block  = blk_top >= CI_W'(cfg.c);
        last       = end_lane && end_kernel && end_col && end_row && end_block;

        elem.dst    = pos_cur;
        elem.ci     = ci;
        elem.kernel = kern_cur;
        elem.row    = row_cur;
        elem.col    = col_cur;
        elem.pad    = pad;
        elem.last   = last;
    end

    always_comb
    begin
        blk_next  = blk_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        kern_next = kern_reg;
        lane_next = lane_reg;
        pos_next  = pos_reg;
        if (accept)
        begin
            if (last)
            begin
                blk_next  = '0;
                row_next  = '0;
                col_next  = '0;
                kern_next = '0;
                lane_next = '0;
                pos_next  = '0;
            end
            else
            begin
                pos_next  = pos_cur + 1'b1;
                blk_next  = blk_cur;
                row_next  = row_cur;
                col_next  = col_cur;
                kern_next = kern_cur;
                lane_next = lane_cur + 1'b1;
                if (end_lane)
                begin
                    lane_next = '0;
                    kern_next = kern_cur + 1'b1;
                    if (end_kernel)
                    begin
                        kern_next = '0;
                        col_next  = col_cur + 1'b1;
                        if (end_col)
                        begin
                            col_next = '0;
                            row_next = row_cur + 1'b1;
                            if (end_row)
                            begin
                                row_next = '0;
                                blk_next = blk_cur + 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            kern_reg <= '0;
            lane_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            blk_reg  <= blk_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            kern_reg <= kern_next;
            lane_reg <= lane_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

[sv/fzw_addr_pipe.sv]
`timescale 1ns / 1ps

module fzw_addr_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fzw_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fzw_pkg::elem_t              elem,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fzw_pkg::DST_W-1:0]   dst_index,
    output logic [fzw_pkg::SRC_W-1:0]   src_index,
    output logic                        zero_fill,
    output logic                        last
);
    import fzw_pkg::*;

    typedef struct packed {
        elem_t            e;
        logic [SRC_W-1:0] acc;
    } stage_t;

    localparam int MUL_W = SRC_W + DIM_W;

    logic   v1_reg, v2_reg, v3_reg, out_valid_reg;
    elem_t  s1_reg;
    stage_t s2_reg, s2_next, s3_reg, s3_next;
    logic   rdy1, rdy2, rdy3, rdy_out;

    logic [DST_W-1:0] dst_reg;
    logic [SRC_W-1:0] src_reg, src_next;
    logic             pad_reg, last_reg;

    logic [KERN_W-1:0]        x0;
    logic [DIM_W-1:0]         m0, m1, m2;
    logic [CI_W-1:0]          a0, a1, a2;
    logic [KERN_W+DIM_W-1:0]  mul1;
    logic [MUL_W-1:0]         mul2, mul3;

    assign rdy_out  = !out_valid_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // the source index is built horner style: ((x0*m0 + a0)*m1 + a1)*m2 + a2
    always_comb
    begin
        case (cfg.layout)
            LAYOUT_HWCN:
            begin
                x0 = KERN_W'(s1_reg.row);
                m0 = DIM_W'(cfg.w);
                a0 = CI_W'(s1_reg.col);
            end
            LAYOUT_NHWC:
            begin
                x0 = s1_reg.kernel;
                m0 = DIM_W'(cfg.h);
                a0 = CI_W'(s1_reg.row);
            end
            default:
            begin
                x0 = s1_reg.kernel;
                m0 = cfg.c;
                a0 = s1_reg.ci;
            end
        endcase
        mul1        = x0 * m0;
        s2_next.e   = s1_reg;
        s2_next.acc = SRC_W'(mul1) + SRC_W'(a0);
    end

    always_comb
    begin
        case (cfg.layout)
            LAYOUT_HWCN:
            begin
                m1 = cfg.c;
                a1 = s2_reg.e.ci;
            end
            LAYOUT_NHWC:
            begin
                m1 = DIM_W'(cfg.w);
                a1 = CI_W'(s2_reg.e.col);
            end
            default:
            begin
                m1 = DIM_W'(cfg.h);
                a1 = CI_W'(s2_reg.e.row);
            end
        endcase
        mul2        = s2_reg.acc * m1;
        s3_next.e   = s2_reg.e;
        s3_next.acc = mul2[SRC_W-1:0] + SRC_W'(a1);
    end

    always_comb
    begin
        case (cfg.layout)
            LAYOUT_HWCN:
            begin
                m2 = cfg.n;
                a2 = CI_W'(s3_reg.e.kernel);
            end
            LAYOUT_NHWC:
            begin
                m2 = cfg.c;
                a2 = s3_reg.e.ci;
            end
            default:
            begin
                m2 = DIM_W'(cfg.w);
                a2 = CI_W'(s3_reg.e.col);
            end
        endcase
        mul3     = s3_reg.acc * m2;
        src_next = s3_reg.e.pad ? '0 : (mul3[SRC_W-1:0] + SRC_W'(a2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy_out)
                out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            s1_reg <= elem;
        if (rdy2)
            s2_reg <= s2_next;
        if (rdy3)
            s3_reg <= s3_next;
        if (rdy_out)
        begin
            dst_reg  <= s3_reg.e.dst;
            src_reg  <= src_next;
            pad_reg  <= s3_reg.e.pad;
            last_reg <= s3_reg.e.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign dst_index = dst_reg;
    assign src_index = src_reg;
    assign zero_fill = pad_reg;
    assign last      = last_reg;

endmodule

[sv/fractal_z_weight_address_gen_unit.sv]
`timescale 1ns / 1ps

// Fractal Z weight address generator: every accepted transaction yields one result
// for the next destination element in (C1, H, W, N1*N0, C0) order, with its source
// index for the configured NCHW, HWCN or NHWC layout, a pad flag and an end-of-pass
// flag; restart set begins again at element 0. One transaction is taken per clock
// cycle while in_stall is low: the counter walk updates in the accepting cycle and
// the element is held in an input register, then the source index is built by three
// multiply-add steps, the first two each ending in a stage register and the last
// feeding the output register. Configuration writes take effect on the next cycle
// and are meant to be made while the block is idle.
module fractal_z_weight_address_gen_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fzw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fzw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fzw_pkg::DST_W-1:0]         dst_index,
    output logic [fzw_pkg::SRC_W-1:0]         src_index,
    output logic                              zero_fill,
    output logic                              last
);
    import fzw_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    elem_t elem;
    logic  pipe_ready;
    logic  accept;

    // registers hold the effective values, clamped on write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIM_N:   cfg_next.n      = clamp_nc(cfg_data);
                CFG_DIM_C:   cfg_next.c      = clamp_nc(cfg_data);
                CFG_DIM_H:   cfg_next.h      = clamp_hw(cfg_data[HW_W-1:0]);
                CFG_DIM_W:   cfg_next.w      = clamp_hw(cfg_data[HW_W-1:0]);
                CFG_CUBE_C0: cfg_next.c0     = clamp_c0(cfg_data[C0_W-1:0]);
                CFG_LAYOUT:  cfg_next.layout = to_layout(cfg_data[1:0]);
                default:     cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.n      <= RST_DIM;
            cfg_reg.c      <= RST_DIM;
            cfg_reg.h      <= RST_HW;
            cfg_reg.w      <= RST_HW;
            cfg_reg.c0     <= RST_C0;
            cfg_reg.layout <= LAYOUT_NCHW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept   = in_valid && pipe_ready;
    assign in_stall = !pipe_ready;

    fzw_walker u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (accept),
        .restart (restart),
        .elem    (elem)
    );

    fzw_addr_pipe u_addr_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (pipe_ready),
        .elem      (elem),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dst_index (dst_index),
        .src_index (src_index),
        .zero_fill (zero_fill),
        .last      (last)
    );

endmodule

[dv/tb_fractal_z_weight_address_gen_unit.sv]
`timescale 1ns / 1ps

module tb_fractal_z_weight_address_gen_unit;
    import fzw_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_LIMIT = 40;
    localparam logic [1:0] LAYOUT_RSVD = 2'd3;

    typedef struct packed {
        logic [DST_W-1:0] dst;
        logic [SRC_W-1:0] src;
        logic             pad;
        logic             last;
    } addr_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  restart = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DST_W-1:0]      dst_index;
    logic [SRC_W-1:0]      src_index;
    logic                  zero_fill;
    logic                  last;

    fractal_z_weight_address_gen_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dst_index (dst_index),
        .src_index (src_index),
        .zero_fill (zero_fill),
        .last      (last)
    );

    // shadow copy of the configuration registers, reset values
    logic [DIM_W-1:0] shadow_n = 13'd1;
    logic [DIM_W-1:0] shadow_c = 13'd1;
    logic [HW_W-1:0]  shadow_h = 8'd1;
    logic [HW_W-1:0]  shadow_w = 8'd1;
    logic [C0_W-1:0]  shadow_c0 = 6'd16;
    logic [1:0]       shadow_layout = 2'd0;

    // destination walk counters
    logic [BLK_W-1:0]  blk_cnt = '0;
    logic [HW_W-1:0]   row_cnt = '0;
    logic [HW_W-1:0]   col_cnt = '0;
    logic [KERN_W-1:0] kern_cnt = '0;
    logic [LANE_W-1:0] lane_cnt = '0;
    logic [DST_W-1:0]  dst_pos = '0;

    addr_result_t expected_addrs[$];
    int unsigned  sent_count = 0;
    int unsigned  got_count = 0;
    int unsigned  mismatches = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  send_idle = 0;
    int unsigned  recv_idle = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
        mismatches++;
    endtask

    task automatic clear_walk();
        blk_cnt = '0;
        row_cnt = '0;
        col_cnt = '0;
        kern_cnt = '0;
        lane_cnt = '0;
        dst_pos = '0;
    endtask

    // produce the element at the current walk position, then advance one step
    task automatic next_element(input logic rs, output addr_result_t r);
        longint unsigned n, c, h, w, c0, c1, n1n0, ci, src;
        bit pad, e_lane, e_kern, e_col, e_row, e_blk, fin;
        n = (shadow_n == 0) ? 1 : ((shadow_n > 4096) ? 4096 : shadow_n);
        c = (shadow_c == 0) ? 1 : ((shadow_c > 4096) ? 4096 : shadow_c);
        h = (shadow_h == 0) ? 1 : shadow_h;
        w = (shadow_w == 0) ? 1 : shadow_w;
        c0 = (shadow_c0 == 0) ? 1 : shadow_c0;
        c1 = (c + c0 - 1) / c0;
        n1n0 = ((n + NI_SIZE - 1) / NI_SIZE) * NI_SIZE;
        if (rs)
            clear_walk();
        ci = longint'(blk_cnt) * c0 + lane_cnt;
        pad = (ci >= c) || (kern_cnt >= n);
        case (layout_t'(shadow_layout))
            LAYOUT_HWCN: src = row_cnt * w * c * n + col_cnt * c * n + ci * n + kern_cnt;
            LAYOUT_NHWC: src = kern_cnt * h * w * c + row_cnt * w * c + col_cnt * c + ci;
            default:     src = kern_cnt * c * h * w + ci * h * w + row_cnt * w + col_cnt;
        endcase
        e_lane = (lane_cnt + 64'd1) >= c0;
        e_kern = (kern_cnt + 64'd1) >= n1n0;
        e_col = (col_cnt + 64'd1) >= w;
        e_row = (row_cnt + 64'd1) >= h;
        e_blk = (blk_cnt + 64'd1) >= c1;
        fin = e_lane && e_kern && e_col && e_row && e_blk;
        r.dst = dst_pos;
        r.src = pad ? '0 : src[SRC_W-1:0];
        r.pad = pad;
        r.last = fin;
        if (fin) begin
            clear_walk();
        end
        else begin
            dst_pos = dst_pos + 1'b1;
            if (!e_lane)
                lane_cnt = lane_cnt + 1'b1;
            else begin
                lane_cnt = '0;
                if (!e_kern)
                    kern_cnt = kern_cnt + 1'b1;
                else begin
                    kern_cnt = '0;
                    if (!e_col)
                        col_cnt = col_cnt + 1'b1;
                    else begin
                        col_cnt = '0;
                        if (!e_row)
                            row_cnt = row_cnt + 1'b1;
                        else begin
                            row_cnt = '0;
                            blk_cnt = blk_cnt + 1'b1;
                        end
                    end
                end
            end
        end
    endtask

    // results are checked before the new transaction is predicted in the same cycle
    always @(posedge clk) begin : scoreboard
        addr_result_t want;
        bit moved;
        if (rst_n) begin
            moved = 1'b0;
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                got_count++;
                if (expected_addrs.size() == 0)
                    report_mismatch("unexpected result dst_index", dst_index, '0);
                else begin
                    want = expected_addrs.pop_front();
                    if (dst_index !== want.dst)
                        report_mismatch("dst_index", dst_index, want.dst);
                    if (src_index !== want.src)
                        report_mismatch("src_index", src_index, want.src);
                    if (zero_fill !== want.pad)
                        report_mismatch("zero_fill", zero_fill, want.pad);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (in_valid && !in_stall) begin
                moved = 1'b1;
                next_element(restart, want);
                expected_addrs.insert(expected_addrs.size(), want);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles > QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_req(input logic rs);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart <= rs;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    // let the pipeline empty so that register writes land while idle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (got_count != sent_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_DIM_N:   shadow_n = val[DIM_W-1:0];
            CFG_DIM_C:   shadow_c = val[DIM_W-1:0];
            CFG_DIM_H:   shadow_h = val[HW_W-1:0];
            CFG_DIM_W:   shadow_w = val[HW_W-1:0];
            CFG_CUBE_C0: shadow_c0 = val[C0_W-1:0];
            CFG_LAYOUT:  shadow_layout = val[1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input int unsigned n, input int unsigned c,
                                input int unsigned h, input int unsigned w,
                                input int unsigned c0, input int unsigned lay);
        wait_drained();
        write_reg(CFG_DIM_N, n);
        write_reg(CFG_DIM_C, c);
        write_reg(CFG_DIM_H, h);
        write_reg(CFG_DIM_W, w);
        write_reg(CFG_CUBE_C0, c0);
        write_reg(CFG_LAYOUT, lay);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // reset values: walk a little, then start over
    task automatic test_reset_config();
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
    endtask

    task automatic test_layouts();
        logic [1:0] lays[4];
        lays = '{LAYOUT_NCHW, LAYOUT_HWCN, LAYOUT_NHWC, LAYOUT_RSVD};
        foreach (lays[i]) begin
            apply_config(3, 5, 2, 3, 4, lays[i]);
            send_req(1'b1);
            send_req(1'b0);
            send_req(1'b0);
        end
    endtask

    // largest shapes, zero fields, oversized fields
    task automatic test_dim_extremes();
        apply_config(4096, 4096, 255, 255, 32, LAYOUT_HWCN);
        send_req(1'b1);
        send_req(1'b0);
        apply_config(0, 0, 0, 0, 0, LAYOUT_NHWC);
        send_req(1'b1);
        send_req(1'b0);
        apply_config(8191, 5000, 255, 255, 63, LAYOUT_RSVD);
        send_req(1'b1);
        send_req(1'b0);
    endtask

    // mostly short passes so that the walk wraps often, some huge shapes,
    // and now and then a new shape without a restart
    task automatic test_random_walks(input int unsigned n_items, input int unsigned s_idle,
                                     input int unsigned r_idle);
        int unsigned done, burst;
        int unsigned c0_pick;
        done = 0;
        send_idle = s_idle;
        recv_idle = r_idle;
        while (done < n_items) begin
            if ($urandom_range(9) == 0) begin
                apply_config($urandom_range(8191), $urandom_range(8191), $urandom_range(255),
                             $urandom_range(255), $urandom_range(63), $urandom_range(3));
            end
            else begin
                c0_pick = $urandom_range(9);
                if (c0_pick == 8)
                    c0_pick = 16;
                else if (c0_pick == 9)
                    c0_pick = 32;
                apply_config($urandom_range(24), $urandom_range(12), $urandom_range(3),
                             $urandom_range(3), c0_pick, $urandom_range(3));
            end
            burst = $urandom_range(40, 300);
            for (int i = 0; i < burst; i++) begin
                if (i == 0)
                    send_req($urandom_range(3) != 0);
                else
                    send_req($urandom_range(47) == 0);
                done++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 35;
        recv_idle = 54;
        test_reset_config();
        test_layouts();
        test_dim_extremes();
        test_random_walks(620, 35, 54);
        test_random_walks(620, 54, 35);
        test_random_walks(620, 0, 0);
        wait_drained();
        if (expected_addrs.size() != 0)
            report_mismatch("results still pending", expected_addrs.size(), 0);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
sv/fzw_pkg.sv
sv/fzw_walker.sv
sv/fzw_addr_pipe.sv
sv/fractal_z_weight_address_gen_unit.sv
dv/tb_fractal_z_weight_address_gen_unit.sv
